/* src/smfm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smfm_pkg
// Shared types and constants for the per-label mean flow magnitude block.
// ----------------------------------------------------------------------------
package smfm_pkg;

  typedef enum logic [1:0] {
    FUNC_ACCUM = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_SQRT,
    ST_RD,
    ST_RDWAIT,
    ST_UPD,
    ST_DIV,
    ST_OUT,
    ST_CLEAR
  } state_e;

  typedef struct packed {
    logic load;
    logic mem_wr_upd;
    logic mem_wr_clr;
    logic clr_step;
    logic div_start;
    logic out_load;
  } ctrl_t;

  typedef struct packed {
    func_e func;
    logic  idx_ok;
    logic  sqrt_done;
    logic  div_done;
    logic  clr_last;
    logic  cnt_full;
  } stat_t;

endpackage

/* src/smfm_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smfm_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module smfm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

/* src/smfm_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smfm_ctrl
// Sequencer: issues datapath commands for each item.
// ----------------------------------------------------------------------------
module smfm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_fire_i,
  input  logic            out_busy_i,
  input  smfm_pkg::stat_t stat_i,
  output smfm_pkg::ctrl_t ctrl_o,
  output logic            in_ready_o
);
  import smfm_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_INIT: begin
        ctrl_o.mem_wr_clr = 1'b1;
        ctrl_o.clr_step   = 1'b1;
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_fire_i) begin
          ctrl_o.load = 1'b1;
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        case (stat_i.func)
          FUNC_ACCUM: state_d = stat_i.idx_ok ? ST_RDWAIT : ST_IDLE;
          FUNC_READ:  state_d = ST_RDWAIT;
          FUNC_CLEAR: state_d = ST_CLEAR;
          default:    state_d = ST_IDLE;
        endcase
      end
      ST_RDWAIT: begin
        if (stat_i.func == FUNC_READ) begin
          ctrl_o.div_start = 1'b1;
          state_d = ST_DIV;
        end else begin
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (stat_i.sqrt_done) state_d = ST_UPD;
      end
      ST_UPD: begin
        ctrl_o.mem_wr_upd = !stat_i.cnt_full;
        state_d = ST_IDLE;
      end
      ST_DIV: begin
        if (stat_i.div_done && !out_busy_i) begin
          ctrl_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        ctrl_o.mem_wr_clr = 1'b1;
        ctrl_o.clr_step   = 1'b1;
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule

/* src/smfm_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smfm_dp
// Datapath: bit-serial square root, store, restoring divider, output register.
// ----------------------------------------------------------------------------
module smfm_dp #(
  parameter int MaxLabels = 1024,
  parameter int CountBits = 20,
  parameter int FracBits  = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  smfm_pkg::ctrl_t ctrl_i,
  output smfm_pkg::stat_t stat_o,
  input  logic [1:0]      func_i,
  input  logic [15:0]     label_i,
  input  logic [15:0]     flow_x_i,
  input  logic [15:0]     flow_y_i,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output logic [23:0]     mean_o,
  output logic [19:0]     total_o,
  output logic [15:0]     largest_o,
  output logic            dropped_o
);
  import smfm_pkg::*;

  localparam int AW   = $clog2(MaxLabels);
  localparam int SW   = CountBits + 16 + FracBits;
  localparam int RW   = 16 + FracBits + 1;
  localparam int QW   = 2 * RW;
  localparam int IW   = $clog2(RW + 1);
  localparam int DIW  = $clog2(SW + 1);
  localparam int LW   = AW + 1;

  logic [1:0]  func_q;
  logic [15:0] label_q;
  logic [31:0] sq_q;
  logic [15:0] largest_q;
  logic        drop_q;

  logic [QW-1:0] rad_q;
  logic [RW-1:0] root_q;
  logic [RW+1:0] rem_q;
  logic [IW-1:0] sit_q;

  logic [SW-1:0] sum_rd, sum_wd;
  logic [CountBits-1:0] cnt_rd, cnt_wd;
  logic [AW-1:0] addr, clr_q;
  logic [15:0] idx;
  logic idx_ok;
  logic we;

  logic [SW-1:0] dq_q;
  logic [CountBits:0] drem_q;
  logic [CountBits-1:0] dden_q;
  logic [DIW-1:0] dit_q;
  logic div_busy_q;

  logic [15:0] ax, ay;
  logic [31:0] ax_sq;
  logic [RW+1:0] trial;
  logic [CountBits:0] dsh;
  logic [SW:0] sum_add;

  assign ax = flow_x_i[15] ? 16'(-flow_x_i) : flow_x_i;
  assign ay = flow_y_i[15] ? 16'(-flow_y_i) : flow_y_i;
  assign ax_sq = ax * ax;

  assign idx    = label_q - 16'd1;
  assign idx_ok = (label_q != '0) && ({16'd0, label_q} <= 32'(MaxLabels));
  assign addr   = (ctrl_i.mem_wr_clr) ? clr_q : idx[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      largest_q <= '0;
      drop_q    <= 1'b0;
    end else if (ctrl_i.load) begin
      if (func_i == FUNC_ACCUM) begin
        if (label_i > largest_q) largest_q <= label_i;
        if ({16'd0, label_i} > 32'(MaxLabels)) drop_q <= 1'b1;
      end else if (func_i == FUNC_CLEAR) begin
        largest_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      func_q  <= func_i;
      label_q <= label_i;
      sq_q    <= ax_sq;
    end
  end

  // second square is added in the following cycle to keep one multiplier per stage
  logic [15:0] ay_q;
  logic [31:0] ay_sq;
  logic        sq_add_q;
  assign ay_sq = ay_q * ay_q;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) ay_q <= ay;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sq_add_q <= 1'b0;
    else         sq_add_q <= ctrl_i.load;
  end

  // restoring square root, one result bit per cycle
  assign trial = {rem_q[RW-1:0], rad_q[QW-1 -: 2]} - {root_q, 2'b01};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sit_q <= '0;
    end else if (sq_add_q) begin
      sit_q <= IW'(RW);
    end else if (sit_q != '0) begin
      sit_q <= sit_q - 1'b1;
    end
  end
  always_ff @(posedge clk_i) begin
    if (sq_add_q) begin
      rad_q  <= QW'({sq_q + ay_sq, {(2 * FracBits){1'b0}}});
      root_q <= '0;
      rem_q  <= '0;
    end else if (sit_q != '0) begin
      rad_q <= {rad_q[QW-3:0], 2'b00};
      if (!trial[RW+1]) begin
        rem_q  <= trial;
        root_q <= {root_q[RW-2:0], 1'b1};
      end else begin
        rem_q  <= {rem_q[RW-1:0], rad_q[QW-1 -: 2]};
        root_q <= {root_q[RW-2:0], 1'b0};
      end
    end
  end

  assign sum_add = {1'b0, sum_rd} + (SW+1)'(root_q);
  assign sum_wd  = ctrl_i.mem_wr_clr ? '0 : (sum_add[SW] ? '1 : sum_add[SW-1:0]);
  assign cnt_wd  = ctrl_i.mem_wr_clr ? '0 : cnt_rd + 1'b1;
  assign we      = ctrl_i.mem_wr_clr | ctrl_i.mem_wr_upd;

  smfm_ram #(.Width(SW), .Depth(MaxLabels)) u_sum (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(sum_wd), .rdata_o(sum_rd)
  );
  smfm_ram #(.Width(CountBits), .Depth(MaxLabels)) u_cnt (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(cnt_wd), .rdata_o(cnt_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (ctrl_i.clr_step) begin
      if (LW'(clr_q) == LW'(MaxLabels - 1)) begin
        clr_q <= '0;
      end else begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  assign dsh = {drem_q[CountBits-1:0], dq_q[SW-1]} - {1'b0, dden_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dit_q      <= '0;
      div_busy_q <= 1'b0;
    end else if (ctrl_i.div_start) begin
      dit_q      <= DIW'(SW);
      div_busy_q <= 1'b1;
    end else if (dit_q != '0) begin
      dit_q <= dit_q - 1'b1;
    end else if (ctrl_i.out_load) begin
      div_busy_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (ctrl_i.div_start) begin
      dq_q   <= idx_ok ? sum_rd : '0;
      dden_q <= idx_ok ? cnt_rd : '0;
      drem_q <= '0;
    end else if (dit_q != '0) begin
      if (!dsh[CountBits]) begin
        drem_q <= dsh;
        dq_q   <= {dq_q[SW-2:0], 1'b1};
      end else begin
        drem_q <= {drem_q[CountBits-1:0], dq_q[SW-1]};
        dq_q   <= {dq_q[SW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (ctrl_i.out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      mean_o    <= (dden_q == '0) ? '0 : 24'(dq_q);
      total_o   <= 20'(dden_q);
      largest_o <= largest_q;
      dropped_o <= drop_q;
    end
  end

  assign stat_o.func      = func_e'(func_q);
  assign stat_o.idx_ok    = idx_ok;
  assign stat_o.sqrt_done = (sit_q == '0) && !sq_add_q;
  assign stat_o.div_done  = (dit_q == '0) && div_busy_q;
  assign stat_o.clr_last  = (LW'(clr_q) == LW'(MaxLabels - 1));
  assign stat_o.cnt_full  = (cnt_rd == '1);
endmodule

/* src/segment_mean_flow_magnitude_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_mean_flow_magnitude_top
// Per-label mean flow magnitude: accumulate, read mean, clear.
// Accumulate: bit-serial square root of RW bits (RW = 17+FRAC_BITS) per item;
// label 0, labels beyond the store and the unused code skip it and the store.
// Read: serial divider over SUM bits (SUM = COUNT_BITS+16+FRAC_BITS); the next
// item is accepted only after the result is loaded, which waits on any output stall.
// Clear: one pass zeroes every store entry. Reset: control clears at once, then a
// pass over every entry zeroes the store with s_axis_tready low.
// ----------------------------------------------------------------------------
module segment_mean_flow_magnitude_top #(
  parameter int MAX_LABELS = 1024,
  parameter int COUNT_BITS = 20,
  parameter int FRAC_BITS  = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // label, flow_x, flow_y
  input  logic [1:0]  s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // mean_magnitude, pixel_total, largest_label,
                                      // dropped, zero fill
);
  import smfm_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  logic  fire;
  logic [23:0] mean;
  logic [19:0] total;
  logic [15:0] largest;
  logic        dropped;

  assign fire = s_axis_tvalid & s_axis_tready;
  assign m_axis_tdata = {3'b000, dropped, largest, total, mean};

  smfm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(fire), .out_busy_i(m_axis_tvalid & ~m_axis_tready),
    .stat_i(stat), .ctrl_o(ctrl), .in_ready_o(s_axis_tready)
  );

  smfm_dp #(.MaxLabels(MAX_LABELS), .CountBits(COUNT_BITS), .FracBits(FRAC_BITS)) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat),
    .func_i(s_axis_tuser), .label_i(s_axis_tdata[15:0]),
    .flow_x_i(s_axis_tdata[31:16]), .flow_y_i(s_axis_tdata[47:32]),
    .out_ready_i(m_axis_tready), .out_valid_o(m_axis_tvalid),
    .mean_o(mean), .total_o(total), .largest_o(largest), .dropped_o(dropped)
  );
endmodule

/* src/smfm_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smfm_chk
// Port-level checks for the mean flow magnitude block.
// ----------------------------------------------------------------------------
module smfm_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);
  import smfm_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result not held");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready after accept");
  a_nores: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser != FUNC_READ
      |=> ##1 !$rose(m_axis_tvalid))
    else $error("result without read");
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[63:61] == 3'b000)
    else $error("fill bits set");
endmodule

bind segment_mean_flow_magnitude_top smfm_chk u_chk (.*);
